/* rtl/ltc_pkg.sv */
// shared constants and types for the tile-tag cache lookup
package ltc_pkg;

  localparam int TILES_DEF      = 16;
  localparam int COORD_BITS_DEF = 20;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET     = 5'd16;
  localparam logic [CAP_W-1:0] CAP_UNLIMITED = 5'h1F;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

/* rtl/ltc_req_if.sv */
// request channel: tile origin in
interface ltc_req_if #(
  parameter int COORD_BITS = ltc_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] tile_x;
  logic [COORD_BITS-1:0] tile_y;

  modport source (output valid, tile_x, tile_y, input ready);
  modport sink   (input valid, tile_x, tile_y, output ready);
endinterface

/* rtl/ltc_rsp_if.sv */
// result channel: hit, entry and eviction report
interface ltc_rsp_if #(
  parameter int COORD_BITS = ltc_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W    = 4
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [ENTRY_W-1:0]    entry;
  logic                  evicted;
  logic [COORD_BITS-1:0] evicted_x;
  logic [COORD_BITS-1:0] evicted_y;

  modport source (output valid, hit, entry, evicted, evicted_x, evicted_y, input ready);
  modport sink   (input valid, hit, entry, evicted, evicted_x, evicted_y, output ready);
endinterface

/* rtl/ltc_ctrl.sv */
// request sequencing: lookup cycle, then update cycle, plus result valid
module ltc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ltc_pkg::cmd_t cmd
);
  import ltc_pkg::*;

  typedef enum logic {S_IDLE, S_UPDATE} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free   = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.commit  = (state_r == S_UPDATE) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // wait here until the output register can take the result
          if (slot_free) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/ltc_dp.sv */
// tag store, recency ranks, parallel lookup and result register
module ltc_dp #(
  parameter int TILES      = ltc_pkg::TILES_DEF,
  parameter int COORD_BITS = ltc_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W    = 4,
  parameter int CNT_W      = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ltc_pkg::cmd_t            cmd,
  input  logic [COORD_BITS-1:0]    req_x,
  input  logic [COORD_BITS-1:0]    req_y,
  input  logic [ltc_pkg::CAP_W-1:0] capacity,
  output logic                     res_hit,
  output logic [ENTRY_W-1:0]       res_entry,
  output logic                     res_evicted,
  output logic [COORD_BITS-1:0]    res_evicted_x,
  output logic [COORD_BITS-1:0]    res_evicted_y
);
  import ltc_pkg::*;

  logic [COORD_BITS-1:0] tag_x_r [TILES];
  logic [COORD_BITS-1:0] tag_y_r [TILES];
  logic                  valid_r [TILES];
  logic [ENTRY_W-1:0]    rank_r  [TILES];
  logic [CNT_W-1:0]      count_r;

  // lookup results held for the update cycle
  logic                  lk_hit_r;
  logic                  lk_fill_r;
  logic                  lk_evict_r;
  logic [ENTRY_W-1:0]    lk_entry_r;
  logic [CNT_W-1:0]      lk_bound_r;
  logic [COORD_BITS-1:0] lk_ev_x_r;
  logic [COORD_BITS-1:0] lk_ev_y_r;
  logic [COORD_BITS-1:0] lk_x_r;
  logic [COORD_BITS-1:0] lk_y_r;

  logic                  hit_any;
  logic [ENTRY_W-1:0]    hit_idx;
  logic                  free_any;
  logic [ENTRY_W-1:0]    free_idx;
  logic [ENTRY_W-1:0]    old_idx;
  logic [ENTRY_W-1:0]    oldest_rank;
  logic [CNT_W-1:0]      eff_cap;
  logic                  fill;
  logic                  evict;
  logic [ENTRY_W-1:0]    sel_idx;
  logic [CNT_W-1:0]      bound;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (capacity == CAP_UNLIMITED || 32'(capacity) > TILES) begin
      eff_cap = CNT_W'(TILES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  // ranks of valid entries form 0..count-1, so the oldest has rank count-1
  assign oldest_rank = ENTRY_W'(count_r - CNT_W'(1));

  // priority encoders, lowest index wins
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    old_idx  = '0;
    for (int i = TILES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_x_r[i] == req_x && tag_y_r[i] == req_y) begin
        hit_any = 1'b1;
        hit_idx = ENTRY_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = ENTRY_W'(i);
      end
      if (valid_r[i] && rank_r[i] == oldest_rank) begin
        old_idx = ENTRY_W'(i);
      end
    end
  end

  assign fill    = !hit_any && free_any && (count_r < eff_cap);
  assign evict   = !hit_any && !fill;
  assign sel_idx = hit_any ? hit_idx : (fill ? free_idx : old_idx);

  always_comb begin
    if (hit_any) begin
      bound = CNT_W'(rank_r[hit_idx]);
    end else if (fill) begin
      bound = count_r;
    end else begin
      bound = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lk_hit_r   <= hit_any;
      lk_fill_r  <= fill;
      lk_evict_r <= evict;
      lk_entry_r <= sel_idx;
      lk_bound_r <= bound;
      lk_ev_x_r  <= evict ? tag_x_r[old_idx] : '0;
      lk_ev_y_r  <= evict ? tag_y_r[old_idx] : '0;
      lk_x_r     <= req_x;
      lk_y_r     <= req_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TILES; j++) begin
        valid_r[j] <= 1'b0;
        rank_r[j]  <= '0;
      end
      count_r <= '0;
    end else if (cmd.commit) begin
      // entries more recent than the chosen one age by one step
      for (int j = 0; j < TILES; j++) begin
        if (valid_r[j] && ENTRY_W'(j) != lk_entry_r &&
            CNT_W'(rank_r[j]) < lk_bound_r) begin
          rank_r[j] <= rank_r[j] + ENTRY_W'(1);
        end
      end
      rank_r[lk_entry_r]  <= '0;
      valid_r[lk_entry_r] <= 1'b1;
      if (lk_fill_r) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tag_x_r[lk_entry_r] <= lk_x_r;
      tag_y_r[lk_entry_r] <= lk_y_r;
      res_hit             <= lk_hit_r;
      res_entry           <= lk_entry_r;
      res_evicted         <= lk_evict_r;
      res_evicted_x       <= lk_ev_x_r;
      res_evicted_y       <= lk_ev_y_r;
    end
  end

endmodule

/* rtl/lru_tile_cache_lookup.sv */
// ordering: the request is captured in the idle state, then committed in the update state, and the
//   result register with its valid flag is loaded at that commit
// a new request is taken only in the idle state, after the last one has committed; parallel tag
//   compare in the accept cycle, rank and tag update in the update state, which waits while the output register is full
// the next request is taken while an earlier result still waits in the output register
// reset: valid bits, ranks and fill count clear at once, capacity_r returns to 16;
//   tags are not cleared and need no clearing pass
module lru_tile_cache_lookup #(
  parameter int TILES      = ltc_pkg::TILES_DEF,
  parameter int COORD_BITS = ltc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ltc_req_if.sink                           in_req,
  ltc_rsp_if.source                         out_rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ltc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ltc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ltc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ltc_pkg::*;

  localparam int ENTRY_W = (TILES > 1) ? $clog2(TILES) : 1;
  localparam int CNT_W   = $clog2(TILES + 1);

  logic [CAP_W-1:0] capacity_r;
  logic             reg_sel;
  cmd_t             cmd;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(capacity_r) : '0;

  ltc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  ltc_dp #(
    .TILES      (TILES),
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .req_x         (in_req.tile_x),
    .req_y         (in_req.tile_y),
    .capacity      (capacity_r),
    .res_hit       (out_rsp.hit),
    .res_entry     (out_rsp.entry),
    .res_evicted   (out_rsp.evicted),
    .res_evicted_x (out_rsp.evicted_x),
    .res_evicted_y (out_rsp.evicted_y)
  );

endmodule

/* tb/ltc_cache_checker.sv */
`timescale 1ns / 1ps
// lookup checker: predicts every tile request's result and compares the result channel
module ltc_cache_checker #(
  parameter int TILES      = ltc_pkg::TILES_DEF,
  parameter int COORD_BITS = ltc_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ltc_req_if                             req,
  ltc_rsp_if                             rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [ltc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ltc_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [ltc_pkg::APB_DATA_W-1:0] prdata,
  output int                             errors,
  output int                             pending,
  output int                             hits,
  output int                             fills,
  output int                             evictions
);
  import ltc_pkg::*;

  localparam int ENTRY_W = $clog2(TILES);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic               hit;
    logic [ENTRY_W-1:0] entry;
    logic               evicted;
    coord_t             evicted_x;
    coord_t             evicted_y;
  } lookup_result_t;

  // resident tiles and their recency, rank 0 is the most recent
  coord_t             res_x [TILES];
  coord_t             res_y [TILES];
  logic               live [TILES];
  logic [ENTRY_W-1:0] age [TILES];
  logic [CAP_W-1:0]   live_count;
  logic [CAP_W-1:0]   cap_reg;

  lookup_result_t expected_results [$];
  int err_n   = 0;
  int hit_n   = 0;
  int fill_n  = 0;
  int evict_n = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_n++;
    $display("%0t: %s mismatch, got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // entries younger than bound age by one step, slot becomes the newest
  function automatic void promote(input int slot, input int bound);
    for (int j = 0; j < TILES; j++) begin
      if (j != slot && live[j] && int'(age[j]) < bound) begin
        age[j] = age[j] + 1'b1;
      end
    end
    age[slot] = '0;
  endfunction

  function automatic lookup_result_t lookup_tile(input coord_t x, input coord_t y);
    lookup_result_t r;
    int             slot;
    int             limit;
    int             oldest;
    logic           found;
    r      = '0;
    slot   = 0;
    oldest = -1;
    found  = 1'b0;
    for (int i = 0; i < TILES; i++) begin
      if (!found && live[i] && res_x[i] == x && res_y[i] == y) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      promote(slot, int'(age[slot]));
      r.hit   = 1'b1;
      r.entry = ENTRY_W'(slot);
      hit_n++;
      return r;
    end
    // zero acts as one, anything above the tile count saturates
    limit = (cap_reg == '0) ? 1 : ((int'(cap_reg) > TILES) ? TILES : int'(cap_reg));
    if (int'(live_count) < limit) begin
      for (int i = 0; i < TILES; i++) begin
        if (!found && !live[i]) begin
          slot  = i;
          found = 1'b1;
        end
      end
    end
    if (found) begin
      promote(slot, int'(live_count));
      live[slot] = 1'b1;
      live_count = live_count + 1'b1;
      fill_n++;
    end else begin
      for (int i = 0; i < TILES; i++) begin
        if (live[i] && int'(age[i]) > oldest) begin
          oldest = int'(age[i]);
          slot   = i;
        end
      end
      r.evicted   = 1'b1;
      r.evicted_x = res_x[slot];
      r.evicted_y = res_y[slot];
      promote(slot, int'(age[slot]));
      evict_n++;
    end
    res_x[slot] = x;
    res_y[slot] = y;
    r.entry     = ENTRY_W'(slot);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lookup_result_t want;
    if (!rst_n) begin
      cap_reg    = CAP_RESET;
      live_count = '0;
      for (int i = 0; i < TILES; i++) begin
        live[i] = 1'b0;
        age[i]  = '0;
      end
      expected_results.delete();
    end else begin
      if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_CAPACITY) begin
        if (pwrite) begin
          cap_reg = pwdata[CAP_W-1:0];
        end else if (prdata !== APB_DATA_W'(cap_reg)) begin
          report_mismatch("capacity readback", prdata, APB_DATA_W'(cap_reg));
        end
      end
      // a result never leaves in its request's accept cycle, so compare first
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result", 32'd1, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.hit !== want.hit) report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
          if (rsp.entry !== want.entry) begin
            report_mismatch("entry", 32'(rsp.entry), 32'(want.entry));
          end
          if (rsp.evicted !== want.evicted) begin
            report_mismatch("evicted", 32'(rsp.evicted), 32'(want.evicted));
          end
          if (rsp.evicted_x !== want.evicted_x) begin
            report_mismatch("evicted_x", 32'(rsp.evicted_x), 32'(want.evicted_x));
          end
          if (rsp.evicted_y !== want.evicted_y) begin
            report_mismatch("evicted_y", 32'(rsp.evicted_y), 32'(want.evicted_y));
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        expected_results.push_back(lookup_tile(req.tile_x, req.tile_y));
      end
    end
    pending   <= expected_results.size();
    errors    <= err_n;
    hits      <= hit_n;
    fills     <= fill_n;
    evictions <= evict_n;
  end

endmodule

/* tb/tb_lru_tile_cache_lookup.sv */
`timescale 1ns / 1ps
// testbench top: drives tile requests, capacity writes and result stalls, gives the verdict
module tb_lru_tile_cache_lookup;
  import ltc_pkg::*;

  localparam int LATENCY        = 2;
  localparam int QUIET_LIMIT    = 1500;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 90;
  localparam int RANDOM_LOOKUPS = 950;
  localparam int CALM_LOOKUPS   = 100;
  localparam int POOL_DEPTH     = 20;
  localparam logic REG_SPARE    = ~REG_CAPACITY;  // register index with nothing behind it

  typedef logic [COORD_BITS_DEF-1:0] coord_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int open_count;
  int hit_count;
  int fill_count;
  int evict_count;

  int lookups_sent  = 0;
  int settings_used = 0;
  int rsp_taken     = 0;
  int holds_done    = 0;
  bit calm          = 1'b0;
  int req_gap_pct   = 0;
  int rsp_stall_pct = 20;

  coord_t pool_x [POOL_DEPTH];
  coord_t pool_y [POOL_DEPTH];

  ltc_req_if req_ch ();
  ltc_rsp_if rsp_ch ();

  lru_tile_cache_lookup i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ltc_cache_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .errors    (fail_count),
    .pending   (open_count),
    .hits      (hit_count),
    .fills     (fill_count),
    .evictions (evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // valid stays high after acceptance, the caller decides whether to drop it
  task automatic send_tile(input coord_t x, input coord_t y);
    req_ch.valid  <= 1'b1;
    req_ch.tile_x <= x;
    req_ch.tile_y <= y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    lookups_sent++;
  endtask

  task automatic cfg_access(input logic idx, input logic wr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_lookups();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [APB_DATA_W-1:0] word;
    word            = $urandom();
    word[CAP_W-1:0] = cap;
    drain_lookups();
    cfg_access(REG_CAPACITY, 1'b1, word);
    cfg_access(REG_CAPACITY, 1'b0, '0);
    settings_used++;
  endtask

  task automatic rsp_tick();
    @(posedge clk);
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) rsp_taken++;
  endtask

  // result side: random stall bursts, plus long hold-offs so the block backs up
  initial begin : rsp_drain
    int len;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && holds_done < 2 && rsp_taken >= HOLD_AT * (holds_done + 1)) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) rsp_tick();
        holds_done++;
      end else if (!calm && $urandom_range(0, 99) < rsp_stall_pct) begin
        rsp_ch.ready <= 1'b0;
        len = $urandom_range(1, 19);
        repeat (len) rsp_tick();
      end else begin
        rsp_ch.ready <= 1'b1;
        len = $urandom_range(1, 30);
        repeat (len) rsp_tick();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) || psel === 1'b1) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int               random_sent;
    int               phase;
    int               span;
    int               pool_n;
    int               pick;
    logic [CAP_W-1:0] cap;
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.tile_x <= '0;
    req_ch.tile_y <= '0;
    random_sent = 0;
    phase       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value, then capacity zero: one entry, every further miss evicts it
    cfg_access(REG_CAPACITY, 1'b0, '0);
    set_capacity('0);
    send_tile('0, '0);
    send_tile('1, '1);
    send_tile('1, '1);
    send_tile('0, '1);
    // unlimited code, and a write to an unmapped index that must change nothing
    set_capacity(CAP_UNLIMITED);
    cfg_access(REG_SPARE, 1'b1, 32'd1);
    cfg_access(REG_CAPACITY, 1'b0, '0);
    send_tile('1, '0);
    send_tile(20'hAAAAA, 20'h55555);
    send_tile(20'h55555, 20'hAAAAA);
    send_tile('0, '1);
    send_tile('1, '0);
    send_tile(20'h12345, 20'h6789A);
    // above the tile count
    set_capacity(5'd17);
    send_tile(20'h00001, 20'h00001);
    send_tile(20'h55555, 20'hAAAAA);
    // lowered below the fill count: misses now replace the oldest entry
    set_capacity(5'd2);
    send_tile(20'h00002, 20'h00002);
    send_tile(20'h00003, 20'h00003);
    send_tile(20'h00002, 20'h00002);
    send_tile(20'hAAAAA, 20'h55555);

    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_x[i] = coord_t'($urandom());
      pool_y[i] = coord_t'($urandom());
    end

    while (random_sent < RANDOM_LOOKUPS) begin
      case (phase)
        0:       cap = 5'd1;
        1:       cap = 5'd16;
        2:       cap = '0;
        3:       cap = CAP_UNLIMITED;
        4:       cap = 5'd17;
        default: cap = CAP_W'($urandom_range(0, 31));
      endcase
      set_capacity(cap);
      // keep part of the working set so old residents can still hit
      for (int i = 0; i < POOL_DEPTH; i++) begin
        if ($urandom_range(0, 99) < 40) begin
          pool_x[i] = coord_t'($urandom());
          pool_y[i] = coord_t'($urandom());
        end
      end
      pool_n = $urandom_range(1, POOL_DEPTH);
      if (RANDOM_LOOKUPS - random_sent <= CALM_LOOKUPS) begin
        calm          = 1'b1;
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
        span          = RANDOM_LOOKUPS - random_sent;
      end else begin
        case ($urandom_range(0, 2))
          0:       req_gap_pct = 0;
          1:       req_gap_pct = 10;
          default: req_gap_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0:       rsp_stall_pct = 0;
          1:       rsp_stall_pct = 15;
          default: rsp_stall_pct = 45;
        endcase
        span = $urandom_range(50, 110);
        if (RANDOM_LOOKUPS - random_sent - span < CALM_LOOKUPS) begin
          span = RANDOM_LOOKUPS - random_sent - CALM_LOOKUPS;
        end
      end
      for (int k = 0; k < span; k++) begin
        if (!calm && $urandom_range(0, 99) < req_gap_pct) begin
          req_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        if ($urandom_range(0, 99) < 85) begin
          pick = $urandom_range(0, pool_n - 1);
          send_tile(pool_x[pick], pool_y[pick]);
        end else begin
          send_tile(coord_t'($urandom()), coord_t'($urandom()));
        end
        random_sent++;
      end
      phase++;
    end

    drain_lookups();
    repeat (LATENCY + 4) @(posedge clk);
    $display("covered %0d tile requests over %0d capacity settings, %0d long result stalls",
             lookups_sent, settings_used, holds_done);
    $display("lookups gave %0d hits, %0d fills and %0d evictions",
             hit_count, fill_count, evict_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
